// File: sv/sspp_pkg.sv
// Shared types and constants for the servo status packet parser.
// No dependencies; every other file of the block refers to this package.
package sspp_pkg;

  // Field widths fixed by the packet format
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;

  // Default number of stored data bytes
  localparam int unsigned MAX_DATA_DEF = 8;

  // Protocol constants
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] MIN_LEN   = 8'd2;

  // Register reset values
  localparam logic [TICKS_W-1:0] TIMEOUT_RST   = 16'd5;
  localparam logic [BYTE_W-1:0]  BROADCAST_RST = 8'd254;
  localparam logic [TICKS_W-1:0] TICKS_MAX     = 16'hFFFF;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 1'b0,
    CFG_BROADCAST = 1'b1
  } cfg_idx_e;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Result outcomes
  typedef enum logic [1:0] {
    OUT_OK       = 2'd0,
    OUT_MISMATCH = 2'd1,
    OUT_TIMEOUT  = 2'd2
  } outcome_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] target_id;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    outcome_e           outcome;
    logic [BYTE_W-1:0]  reply_id;
    logic [BYTE_W-1:0]  reply_error;
    logic [COUNT_W-1:0] data_count;
    logic [DATA_W-1:0]  reply_data;
  } result_t;

  typedef struct packed {
    logic [TICKS_W-1:0] timeout_ticks;
    logic [BYTE_W-1:0]  broadcast_id;
  } cfg_t;

endpackage

// File: sv/sspp_in_if.sv
// Request channel of the servo status packet parser: valid, ready, payload.
// Depends on sspp_pkg for field widths.
interface sspp_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [sspp_pkg::BYTE_W-1:0] target_id;
  logic [sspp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output kind, output target_id, output rx_byte,
                  input ready);
  modport sink   (input valid, input kind, input target_id, input rx_byte,
                  output ready);
endinterface

// File: sv/sspp_out_if.sv
// Result channel of the servo status packet parser: valid, ready, payload.
// Depends on sspp_pkg for field widths.
interface sspp_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   outcome;
  logic [sspp_pkg::BYTE_W-1:0]  reply_id;
  logic [sspp_pkg::BYTE_W-1:0]  reply_error;
  logic [sspp_pkg::COUNT_W-1:0] data_count;
  logic [sspp_pkg::DATA_W-1:0]  reply_data;

  modport source (output valid, output outcome, output reply_id, output reply_error,
                  output data_count, output reply_data, input ready);
  modport sink   (input valid, input outcome, input reply_id, input reply_error,
                  input data_count, input reply_data, output ready);
endinterface

// File: sv/sspp_in_reg.sv
// Input register of the parser: holds one request until the parser takes it.
// Depends on sspp_pkg for the request type.
module sspp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  sspp_pkg::item_t item_i,
  input  logic            take_i,
  output logic            valid_o,
  output sspp_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  sspp_pkg::item_t item_q;

  // Accept when empty or when the held request leaves this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: sv/sspp_parser.sv
// Packet state machine, running checksum, data store and config registers.
// Depends on sspp_pkg; one request is processed per cycle when take_i is high.
module sspp_parser #(
  parameter int unsigned MAX_DATA = sspp_pkg::MAX_DATA_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sspp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sspp_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            take_i,
  input  sspp_pkg::item_t                 item_i,
  output logic                            res_valid_o,
  output sspp_pkg::result_t               res_o
);

  localparam int unsigned IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int unsigned NBYTES = sspp_pkg::DATA_W / sspp_pkg::BYTE_W;

  typedef enum logic [5:0] {
    PH_SYNC = 6'b000001,
    PH_ID   = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_ERR  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_SUM  = 6'b100000
  } phase_e;

  sspp_pkg::cfg_t cfg_q;

  logic                          active_q, active_d;
  phase_e                        phase_q, phase_d;
  logic                          sync_q, sync_d;
  logic [sspp_pkg::BYTE_W-1:0]   want_id_q, want_id_d;
  logic [sspp_pkg::BYTE_W-1:0]   got_id_q, got_id_d;
  logic [sspp_pkg::BYTE_W-1:0]   got_len_q, got_len_d;
  logic [sspp_pkg::BYTE_W-1:0]   got_err_q, got_err_d;
  logic [sspp_pkg::BYTE_W-1:0]   idx_q, idx_d;
  logic [sspp_pkg::BYTE_W-1:0]   sum_q, sum_d;
  logic [sspp_pkg::TICKS_W-1:0]  ticks_q, ticks_d;

  logic [sspp_pkg::BYTE_W-1:0]   store_q [MAX_DATA];
  logic                          store_we;

  logic [sspp_pkg::BYTE_W-1:0]   b;
  logic [sspp_pkg::BYTE_W-1:0]   len_m2;
  logic [sspp_pkg::BYTE_W-1:0]   idx_inc;
  logic [sspp_pkg::TICKS_W-1:0]  ticks_inc;
  logic [sspp_pkg::COUNT_W-1:0]  count;
  logic [sspp_pkg::DATA_W-1:0]   packed_data;

  assign b       = item_i.rx_byte;
  assign len_m2  = got_len_q - sspp_pkg::MIN_LEN;
  assign idx_inc = idx_q + 8'd1;
  assign ticks_inc = (ticks_q == sspp_pkg::TICKS_MAX) ? ticks_q : ticks_q + 16'd1;

  // Cap the stored byte count
  assign count = (len_m2 > sspp_pkg::BYTE_W'(MAX_DATA)) ?
                 sspp_pkg::COUNT_W'(MAX_DATA) : len_m2[sspp_pkg::COUNT_W-1:0];

  // Pack stored bytes, zero at and above the count
  always_comb begin
    packed_data = '0;
    for (int i = 0; i < NBYTES; i++) begin
      if ((i < MAX_DATA) && (sspp_pkg::COUNT_W'(i) < count)) begin
        packed_data[i*sspp_pkg::BYTE_W +: sspp_pkg::BYTE_W] = store_q[IDX_W'(i)];
      end
    end
  end

  // Next state and result for the request in hand
  always_comb begin
    active_d  = active_q;
    phase_d   = phase_q;
    sync_d    = sync_q;
    want_id_d = want_id_q;
    got_id_d  = got_id_q;
    got_len_d = got_len_q;
    got_err_d = got_err_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    ticks_d   = ticks_q;
    store_we  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (take_i) begin
      case (item_i.kind)
        sspp_pkg::KIND_START: begin
          active_d  = 1'b1;
          want_id_d = item_i.target_id;
          ticks_d   = '0;
          idx_d     = '0;
          sum_d     = '0;
          phase_d   = PH_SYNC;
          sync_d    = 1'b0;
        end
        sspp_pkg::KIND_BYTE: begin
          if (active_q && (ticks_q < cfg_q.timeout_ticks)) begin
            case (phase_q)
              PH_SYNC: begin
                if (b == sspp_pkg::SYNC_BYTE) begin
                  if (sync_q) begin
                    phase_d = PH_ID;
                    sync_d  = 1'b0;
                  end else begin
                    sync_d = 1'b1;
                  end
                end else begin
                  sync_d = 1'b0;
                end
              end
              PH_ID: begin
                // Skip extra sync bytes; drop foreign ids unless broadcast
                if (b != sspp_pkg::SYNC_BYTE) begin
                  if ((want_id_q != cfg_q.broadcast_id) && (b != want_id_q)) begin
                    phase_d = PH_SYNC;
                    sync_d  = 1'b0;
                  end else begin
                    got_id_d = b;
                    sum_d    = b;
                    phase_d  = PH_LEN;
                  end
                end
              end
              PH_LEN: begin
                if (b < sspp_pkg::MIN_LEN) begin
                  phase_d = PH_SYNC;
                  sync_d  = 1'b0;
                end else begin
                  got_len_d = b;
                  sum_d     = sum_q + b;
                  phase_d   = PH_ERR;
                end
              end
              PH_ERR: begin
                got_err_d = b;
                sum_d     = sum_q + b;
                idx_d     = '0;
                phase_d   = (got_len_q > sspp_pkg::MIN_LEN) ? PH_DATA : PH_SUM;
              end
              PH_DATA: begin
                // Store the first bytes, sum them all
                store_we = (idx_q < sspp_pkg::BYTE_W'(MAX_DATA));
                sum_d    = sum_q + b;
                idx_d    = idx_inc;
                if (idx_inc >= len_m2) begin
                  phase_d = PH_SUM;
                end
              end
              PH_SUM: begin
                res_valid_o       = 1'b1;
                res_o.outcome     = (b == ~sum_q) ? sspp_pkg::OUT_OK : sspp_pkg::OUT_MISMATCH;
                res_o.reply_id    = got_id_q;
                res_o.reply_error = got_err_q;
                res_o.data_count  = count;
                res_o.reply_data  = packed_data;
                active_d = 1'b0;
                phase_d  = PH_SYNC;
                sync_d   = 1'b0;
              end
              default: begin
                phase_d = PH_SYNC;
                sync_d  = 1'b0;
              end
            endcase
          end
        end
        sspp_pkg::KIND_TICK: begin
          if (active_q) begin
            ticks_d = ticks_inc;
            if (ticks_inc >= cfg_q.timeout_ticks) begin
              res_valid_o   = 1'b1;
              res_o.outcome = sspp_pkg::OUT_TIMEOUT;
              active_d = 1'b0;
              phase_d  = PH_SYNC;
              sync_d   = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      phase_q   <= PH_SYNC;
      sync_q    <= 1'b0;
      want_id_q <= '0;
      got_id_q  <= '0;
      got_len_q <= '0;
      got_err_q <= '0;
      idx_q     <= '0;
      sum_q     <= '0;
      ticks_q   <= '0;
    end else begin
      active_q  <= active_d;
      phase_q   <= phase_d;
      sync_q    <= sync_d;
      want_id_q <= want_id_d;
      got_id_q  <= got_id_d;
      got_len_q <= got_len_d;
      got_err_q <= got_err_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      ticks_q   <= ticks_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= sspp_pkg::TIMEOUT_RST;
      cfg_q.broadcast_id  <= sspp_pkg::BROADCAST_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sspp_pkg::CFG_TIMEOUT:   cfg_q.timeout_ticks <= cfg_wdata_i;
        sspp_pkg::CFG_BROADCAST: cfg_q.broadcast_id  <= cfg_wdata_i[sspp_pkg::BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Data store, no reset
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[idx_q[IDX_W-1:0]] <= b;
    end
  end

  // A result comes only from an armed parser
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> active_q)
    else $error("result from idle parser");

  // Start arms the parser at sync
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && item_i.kind == sspp_pkg::KIND_START) |=> (active_q && phase_q == PH_SYNC))
    else $error("start did not arm parser");

  // Every result leaves the parser idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (!active_q && phase_q == PH_SYNC && !sync_q))
    else $error("parser still armed after result");

  // Timeouts come from ticks only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.outcome == sspp_pkg::OUT_TIMEOUT) |->
    (item_i.kind == sspp_pkg::KIND_TICK))
    else $error("timeout without tick");

endmodule

// File: sv/sspp_out_reg.sv
// Result register of the parser: holds one result until the receiver takes it.
// Depends on sspp_pkg for the result type.
module sspp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic              res_valid_i,
  input  sspp_pkg::result_t res_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output sspp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  sspp_pkg::result_t res_q;

  // Slot is free when empty or emptied this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = res_valid_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: sv/servo_status_packet_parser.sv
// Top level of the servo status packet parser.
// Depends on sspp_pkg, sspp_in_if, sspp_out_if, sspp_in_reg, sspp_parser, sspp_out_reg.
//
// Usage:
//   in_i carries requests: kind 0 arms the parser with target_id and clears
//   the tick count, kind 1 delivers one bus byte, kind 2 is a 1 ms tick.
//   out_o carries results: ok or checksum mismatch on the checksum byte of a
//   status packet, or timeout when the tick count reaches timeout_ticks.
//   Registers (cfg_we_i, cfg_index_i, cfg_wdata_i): index 0 timeout_ticks,
//   index 1 broadcast_id; write them only while no request is in flight.
// Throughput:
//   One request per cycle while the result slot is free. A request is held
//   in the input register until the parser takes it, and its result is then
//   written into the result register.
//   The rate is set by the combinational parser step on the running checksum.
// Reset:
//   The parser is idle, timeout_ticks is 5 and broadcast_id is 254.
// Stall:
//   While a result waits on out_o, the request held in the input register
//   waits too; in_i.ready drops once that register is full.
module servo_status_packet_parser #(
  parameter int unsigned MAX_DATA = sspp_pkg::MAX_DATA_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sspp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sspp_pkg::CFG_W-1:0]     cfg_wdata_i,
  sspp_in_if.sink                        in_i,
  sspp_out_if.source                     out_o
);

  sspp_pkg::item_t   in_item;
  sspp_pkg::item_t   held_item;
  logic              held_valid;
  logic              take;
  logic              out_free;
  logic              res_valid;
  sspp_pkg::result_t res;
  sspp_pkg::result_t out_res;

  // Pack the request payload
  assign in_item.kind      = sspp_pkg::kind_e'(in_i.kind);
  assign in_item.target_id = in_i.target_id;
  assign in_item.rx_byte   = in_i.rx_byte;

  // Advance the held request when the result slot is free
  assign take = held_valid && out_free;

  sspp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .take_i  (take),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  sspp_parser #(
    .MAX_DATA (MAX_DATA)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sspp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .res_o       (out_res)
  );

  // Unpack the result payload
  assign out_o.outcome     = out_res.outcome;
  assign out_o.reply_id    = out_res.reply_id;
  assign out_o.reply_error = out_res.reply_error;
  assign out_o.data_count  = out_res.data_count;
  assign out_o.reply_data  = out_res.reply_data;

endmodule

// File: tb/sv/sspp_reply_checker.sv
`timescale 1ns / 1ps
// Result checker for the servo status packet parser: predicts every reply from the
// accepted requests and register writes, and compares what leaves the result channel.
// Depends on sspp_pkg for field widths, request kinds, outcomes and register indexes.
module sspp_reply_checker
  import sspp_pkg::*;
#(
  parameter int unsigned MAX_DATA = MAX_DATA_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  logic [1:0]           req_kind_i,
  input  logic [BYTE_W-1:0]    req_target_id_i,
  input  logic [BYTE_W-1:0]    req_rx_byte_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [1:0]           res_outcome_i,
  input  logic [BYTE_W-1:0]    res_reply_id_i,
  input  logic [BYTE_W-1:0]    res_reply_error_i,
  input  logic [COUNT_W-1:0]   res_data_count_i,
  input  logic [DATA_W-1:0]    res_reply_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);

  typedef enum logic [2:0] {
    P_HUNT = 3'd0,
    P_ID   = 3'd1,
    P_LEN  = 3'd2,
    P_ERR  = 3'd3,
    P_DATA = 3'd4,
    P_SUM  = 3'd5
  } parse_phase_e;

  // Register copies
  logic [TICKS_W-1:0] timeout_ticks;
  logic [BYTE_W-1:0]  broadcast_id;

  // Parser state as the block should hold it
  logic               armed;
  parse_phase_e       phase;
  logic               sync_seen;
  logic [BYTE_W-1:0]  want_id;
  logic [BYTE_W-1:0]  got_id;
  logic [BYTE_W-1:0]  got_len;
  logic [BYTE_W-1:0]  got_err;
  logic [BYTE_W-1:0]  data_idx;
  logic [BYTE_W-1:0]  run_sum;
  logic [BYTE_W-1:0]  data_bytes [MAX_DATA];
  logic [TICKS_W-1:0] elapsed;

  result_t     expected_replies [$];
  int unsigned mismatch_count;
  int unsigned pending;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = pending;

  function automatic void restart_hunt();
    phase     = P_HUNT;
    sync_seen = 1'b0;
  endfunction

  // Advance the packet framing by one bus byte; returns 1 on the checksum byte
  function automatic bit take_bus_byte(input logic [BYTE_W-1:0] b, output result_t r);
    int unsigned       n;
    logic [DATA_W-1:0] packed_data;
    r = '0;
    case (phase)
      P_HUNT: begin
        if (b == SYNC_BYTE) begin
          if (sync_seen) begin
            phase     = P_ID;
            sync_seen = 1'b0;
          end else begin
            sync_seen = 1'b1;
          end
        end else begin
          sync_seen = 1'b0;
        end
      end
      P_ID: begin
        // extra sync bytes are skipped here
        if (b != SYNC_BYTE) begin
          if (want_id != broadcast_id && b != want_id) begin
            restart_hunt();
          end else begin
            got_id  = b;
            run_sum = b;
            phase   = P_LEN;
          end
        end
      end
      P_LEN: begin
        if (b < MIN_LEN) begin
          restart_hunt();
        end else begin
          got_len = b;
          run_sum = run_sum + b;
          phase   = P_ERR;
        end
      end
      P_ERR: begin
        got_err  = b;
        run_sum  = run_sum + b;
        data_idx = '0;
        phase    = (got_len > MIN_LEN) ? P_DATA : P_SUM;
      end
      P_DATA: begin
        // bytes past the store still count in the checksum
        if (data_idx < MAX_DATA) data_bytes[data_idx] = b;
        run_sum  = run_sum + b;
        data_idx = data_idx + 8'd1;
        if (data_idx >= got_len - MIN_LEN) phase = P_SUM;
      end
      P_SUM: begin
        n = got_len - MIN_LEN;
        if (n > MAX_DATA) n = MAX_DATA;
        packed_data = '0;
        for (int i = 0; i < n; i++) packed_data[8*i +: 8] = data_bytes[i];
        r.outcome     = (b == ~run_sum) ? OUT_OK : OUT_MISMATCH;
        r.reply_id    = got_id;
        r.reply_error = got_err;
        r.data_count  = COUNT_W'(n);
        r.reply_data  = packed_data;
        armed = 1'b0;
        restart_hunt();
        return 1'b1;
      end
      default: restart_hunt();
    endcase
    return 1'b0;
  endfunction

  // Apply one accepted request; returns 1 when it produces a reply
  function automatic bit step_parser(input kind_e k, input logic [BYTE_W-1:0] eid,
                                     input logic [BYTE_W-1:0] b, output result_t r);
    r = '0;
    case (k)
      KIND_START: begin
        armed    = 1'b1;
        want_id  = eid;
        elapsed  = '0;
        data_idx = '0;
        run_sum  = '0;
        restart_hunt();
      end
      KIND_BYTE: begin
        // a byte after the time has run out is dropped
        if (armed && elapsed < timeout_ticks) return take_bus_byte(b, r);
      end
      KIND_TICK: begin
        if (armed) begin
          if (elapsed != TICKS_MAX) elapsed = elapsed + 16'd1;
          if (elapsed >= timeout_ticks) begin
            r.outcome = OUT_TIMEOUT;
            armed     = 1'b0;
            restart_hunt();
            return 1'b1;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Track register writes, score replies, predict from requests
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    result_t oldest;
    result_t fresh;
    if (!rst_ni) begin
      timeout_ticks = TIMEOUT_RST;
      broadcast_id  = BROADCAST_RST;
      armed         = 1'b0;
      want_id       = '0;
      got_id        = '0;
      got_len       = '0;
      got_err       = '0;
      data_idx      = '0;
      run_sum       = '0;
      elapsed       = '0;
      for (int i = 0; i < MAX_DATA; i++) data_bytes[i] = '0;
      restart_hunt();
      expected_replies.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TIMEOUT:   timeout_ticks = cfg_wdata_i[TICKS_W-1:0];
          CFG_BROADCAST: broadcast_id  = cfg_wdata_i[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply: outcome %0h id %0h error %0h count %0h data %0h",
                 res_outcome_i, res_reply_id_i, res_reply_error_i, res_data_count_i,
                 res_reply_data_i);
          mismatch_count++;
        end else begin
          oldest = expected_replies.pop_front();
          check_field("outcome", oldest.outcome, res_outcome_i);
          check_field("reply_id", oldest.reply_id, res_reply_id_i);
          check_field("reply_error", oldest.reply_error, res_reply_error_i);
          check_field("data_count", oldest.data_count, res_data_count_i);
          check_field("reply_data", oldest.reply_data, res_reply_data_i);
        end
      end
      if (req_valid_i && req_ready_i) begin
        if (step_parser(kind_e'(req_kind_i), req_target_id_i, req_rx_byte_i, fresh))
          expected_replies.push_back(fresh);
      end
    end
    pending = expected_replies.size();
  end

endmodule

// File: tb/sv/servo_status_packet_parser_tb.sv
`timescale 1ns / 1ps
// Testbench top for the servo status packet parser: drives requests and registers,
// holds off the result side at random, and reports the verdict from the checker.
// Depends on sspp_pkg, sspp_in_if, sspp_out_if, sspp_reply_checker and the block.
module servo_status_packet_parser_tb;
  import sspp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 380;
  localparam int unsigned HOLD_CYCLES = 90;
  localparam int unsigned DRAIN_PAUSE = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned item_cnt = 0;
  int unsigned tick_pct = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  logic [TICKS_W-1:0] cur_tmo = TIMEOUT_RST;
  logic [BYTE_W-1:0]  cur_bcast = BROADCAST_RST;

  // Register settings of the random phases, extremes included
  logic [TICKS_W-1:0] tmo_set [5] = '{16'hFFFF, 16'd3, 16'd20, 16'd1, 16'h8000};
  logic [BYTE_W-1:0]  bc_set  [5] = '{8'h00, 8'hFF, 8'hFE, 8'h5A, 8'h01};

  sspp_in_if  req_ch ();
  sspp_out_if res_ch ();

  servo_status_packet_parser u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_ch),
    .out_o       (res_ch)
  );

  sspp_reply_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .req_valid_i       (req_ch.valid),
    .req_ready_i       (req_ch.ready),
    .req_kind_i        (req_ch.kind),
    .req_target_id_i   (req_ch.target_id),
    .req_rx_byte_i     (req_ch.rx_byte),
    .res_valid_i       (res_ch.valid),
    .res_ready_i       (res_ch.ready),
    .res_outcome_i     (res_ch.outcome),
    .res_reply_id_i    (res_ch.reply_id),
    .res_reply_error_i (res_ch.reply_error),
    .res_data_count_i  (res_ch.data_count),
    .res_reply_data_i  (res_ch.reply_data),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one request, idling at random first, and hold it until accepted
  task automatic push_req(input kind_e k, input logic [BYTE_W-1:0] eid,
                          input logic [BYTE_W-1:0] b);
    while (!no_idle && $urandom_range(99) < 22) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= k;
    req_ch.target_id <= eid;
    req_ch.rx_byte   <= b;
    do @(posedge clk); while (!req_ch.ready);
    item_cnt++;
  endtask

  task automatic arm(input logic [BYTE_W-1:0] want);
    push_req(KIND_START, want, 8'($urandom));
  endtask

  // Deliver a bus byte, sometimes preceded by a tick
  task automatic bus_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < tick_pct) push_req(KIND_TICK, 8'($urandom), 8'($urandom));
    push_req(KIND_BYTE, 8'($urandom), b);
  endtask

  // Frame a status packet and send its first cut bytes (all of them when cut is 0)
  task automatic send_reply(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] len,
                            input logic [BYTE_W-1:0] err, input bit corrupt,
                            input int unsigned extra_sync, input int unsigned cut);
    logic [BYTE_W-1:0] frame [$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] v;
    frame = '{SYNC_BYTE, SYNC_BYTE};
    repeat (extra_sync) frame.push_back(SYNC_BYTE);
    frame.push_back(id);
    frame.push_back(len);
    frame.push_back(err);
    sum = id + len + err;
    for (int i = 2; i < len; i++) begin
      v = 8'($urandom);
      frame.push_back(v);
      sum = sum + v;
    end
    v = ~sum;
    if (corrupt) v = v ^ 8'($urandom_range(1, 255));
    frame.push_back(v);
    foreach (frame[i]) begin
      if (cut == 0 || i < cut) bus_byte(frame[i]);
    end
  endtask

  // Drop valid, wait for every reply, then let the pipeline drain
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic program_regs(input logic [TICKS_W-1:0] tmo, input logic [BYTE_W-1:0] bc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= CFG_BROADCAST;
    cfg_wdata <= {8'h00, bc};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_tmo   = tmo;
    cur_bcast = bc;
  endtask

  // One random transaction: mostly armed packets, some tick-outs, some noise
  task automatic run_transaction();
    int unsigned       pick;
    int unsigned       len_pick;
    logic [BYTE_W-1:0] want;
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] len;
    pick = $urandom_range(99);
    if (pick < 70) begin
      want = ($urandom_range(99) < 20) ? cur_bcast : 8'($urandom);
      arm(want);
      repeat ($urandom_range(0, 2))
        bus_byte(($urandom_range(99) < 30) ? SYNC_BYTE : 8'($urandom));
      if (want == cur_bcast || $urandom_range(99) < 8) id = 8'($urandom_range(0, 254));
      else id = want;
      // small lengths mostly, broken and very long ones rarely
      len_pick = $urandom_range(99);
      if (len_pick < 5) len = 8'($urandom_range(0, 1));
      else if (len_pick < 83) len = 8'($urandom_range(2, 12));
      else if (len_pick < 98) len = 8'($urandom_range(13, 40));
      else len = 8'($urandom_range(200, 255));
      send_reply(id, len, 8'($urandom), $urandom_range(99) < 20, $urandom_range(0, 1),
                 ($urandom_range(99) < 8) ? $urandom_range(1, 5) : 0);
    end else if (pick < 85) begin
      arm(8'($urandom));
      repeat ((cur_tmo <= 64) ? cur_tmo + 1 : 3) begin
        push_req(KIND_TICK, 8'($urandom), 8'($urandom));
        if ($urandom_range(99) < 30) bus_byte(8'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 6))
        push_req(kind_e'($urandom_range(0, 3)), 8'($urandom),
                 ($urandom_range(99) < 30) ? SYNC_BYTE : 8'($urandom));
    end
  endtask

  // Result side: random back-pressure, one long hold-off on request
  initial begin : sink_side
    int unsigned hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= 22);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("servo_status_packet_parser verification failed");
    $finish;
  end

  initial begin : stimulus
    cfg_we           = 1'b0;
    cfg_index        = CFG_TIMEOUT;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_NONE;
    req_ch.target_id = '0;
    req_ch.rx_byte   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle parser ignores bytes, ticks and unknown kinds
    push_req(KIND_TICK, 8'h00, 8'h00);
    push_req(KIND_BYTE, 8'hFF, 8'hFF);
    push_req(KIND_NONE, 8'h00, 8'hFF);
    // Good empty reply with an extra sync byte; unknown kind while armed
    arm(8'h01);
    push_req(KIND_NONE, 8'hFF, 8'h00);
    send_reply(8'h01, 8'd2, 8'h00, 1'b0, 1, 0);
    // Broadcast expected id accepts any reply id; bad checksum
    arm(BROADCAST_RST);
    send_reply(8'h00, 8'd3, 8'hFF, 1'b1, 0, 0);
    // Timeout after the reset tick budget
    arm(8'hFF);
    repeat (5) push_req(KIND_TICK, 8'($urandom), 8'($urandom));
    quiesce();
    // Zero budget: time has already run out, bytes dropped, first tick times out
    program_regs(16'd0, BROADCAST_RST);
    arm(8'h01);
    push_req(KIND_BYTE, 8'h00, SYNC_BYTE);
    push_req(KIND_TICK, 8'hFF, 8'h00);

    // Random phases, one register setting each
    tick_pct = 3;
    for (int p = 0; p < 5; p++) begin
      int unsigned stop_at;
      quiesce();
      program_regs(tmo_set[p], bc_set[p]);
      no_idle = (p == 2);
      if (p == 1) hold_req = 1'b1;
      stop_at = item_cnt + PHASE_ITEMS;
      while (item_cnt < stop_at) run_transaction();
    end
    no_idle = 1'b0;
    quiesce();

    if (mismatches == 0) begin
      $display("servo_status_packet_parser verification clean");
    end else begin
      $display("servo_status_packet_parser verification failed");
    end
    $finish;
  end

endmodule
